@@ rtl/core/cps_pkg.sv @@
// shared constants, codes and types for the charlieplexed led pwm scanner
package cps_pkg;

	localparam int TICKS_PER_LED = 4;
	localparam int PORT_BITS     = 8;
	localparam int MAX_LEDS      = 240;

	localparam int TICK_W  = $clog2(TICKS_PER_LED + 1);
	localparam int LED_W   = $clog2(MAX_LEDS);
	localparam int CNT_W   = $clog2(MAX_LEDS + 1);
	localparam int PCNT_W  = $clog2(PORT_BITS + 1);
	localparam int PSEL_W  = $clog2(PORT_BITS);
	localparam int N_W     = $clog2(2 * PORT_BITS + 1);

	// action codes
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_SET   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LOW_FIRST  = 2'd0;
	localparam logic [1:0] CFG_LOW_COUNT  = 2'd1;
	localparam logic [1:0] CFG_HIGH_FIRST = 2'd2;
	localparam logic [1:0] CFG_HIGH_COUNT = 2'd3;

	typedef struct packed {
		logic [PORT_BITS-1:0] low_dir;
		logic [PORT_BITS-1:0] low_lvl;
		logic [PORT_BITS-1:0] high_dir;
		logic [PORT_BITS-1:0] high_lvl;
	} port_masks_t;

	// pin layout as seen by the decoder, counts already limited to the port
	typedef struct packed {
		logic [PCNT_W-1:0] n_low;
		logic [PCNT_W-1:0] n_high;
		logic [PSEL_W-1:0] s_low;
		logic [PSEL_W-1:0] s_high;
	} pin_cfg_t;

endpackage

@@ rtl/core/cps_led_decode.sv @@
// led number to pin direction and level masks, one pin row per cycle
module cps_led_decode (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cps_pkg::LED_W-1:0]      led,
	input  cps_pkg::pin_cfg_t              pins,
	output logic                           done,
	output cps_pkg::port_masks_t           masks
);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_WALK = 2'd1;
	localparam logic [1:0] D_OUT  = 2'd2;

	logic [1:0]                  state_q;
	logic [cps_pkg::LED_W-2:0]   pair_q;
	logic                        pol_q;
	logic [cps_pkg::LED_W-1:0]   row_start_q;
	logic [cps_pkg::N_W-1:0]     pin_a_q;
	logic [cps_pkg::N_W-1:0]     pin_b_q;
	logic                        hit_q;

	logic [cps_pkg::N_W-1:0]     n_pins;
	logic [cps_pkg::N_W-1:0]     row_len;
	logic [cps_pkg::LED_W-1:0]   row_end;
	logic [cps_pkg::LED_W-1:0]   offset;
	logic [cps_pkg::PORT_BITS-1:0] bit_a;
	logic [cps_pkg::PORT_BITS-1:0] bit_b;
	logic                        high_a;
	logic                        high_b;

	// one-hot bit of a global pin in its port, zero when it falls off the port
	function automatic logic [cps_pkg::PORT_BITS:0] pin_bit(
		input logic [cps_pkg::N_W-1:0] x,
		input cps_pkg::pin_cfg_t       p
	);
		logic                        is_high;
		logic [cps_pkg::N_W:0]       pos;
		logic [cps_pkg::PORT_BITS-1:0] b;
		is_high = (x >= cps_pkg::N_W'(p.n_low));
		if (is_high) begin
			pos = (cps_pkg::N_W+1)'(p.s_high) + (cps_pkg::N_W+1)'(x - cps_pkg::N_W'(p.n_low));
		end else begin
			pos = (cps_pkg::N_W+1)'(p.s_low) + (cps_pkg::N_W+1)'(x);
		end
		b = '0;
		if (pos < (cps_pkg::N_W+1)'(cps_pkg::PORT_BITS)) begin
			b[pos[cps_pkg::PSEL_W-1:0]] = 1'b1;
		end
		return {is_high, b};
	endfunction

	assign n_pins  = cps_pkg::N_W'(pins.n_low) + cps_pkg::N_W'(pins.n_high);
	assign row_len = n_pins - pin_a_q - cps_pkg::N_W'(1);
	assign row_end = row_start_q + cps_pkg::LED_W'(row_len);
	assign offset  = cps_pkg::LED_W'(pair_q) - row_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_WALK;
					end
				end
				D_WALK: begin
					if (pin_a_q >= n_pins || cps_pkg::LED_W'(pair_q) < row_end) begin
						state_q <= D_OUT;
					end
				end
				D_OUT: state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					pair_q      <= led[cps_pkg::LED_W-1:1];
					pol_q       <= led[0];
					row_start_q <= '0;
					pin_a_q     <= '0;
					hit_q       <= 1'b0;
				end
			end
			D_WALK: begin
				if (pin_a_q >= n_pins) begin
					hit_q <= 1'b0;
				end else if (cps_pkg::LED_W'(pair_q) < row_end) begin
					hit_q   <= 1'b1;
					pin_b_q <= pin_a_q + cps_pkg::N_W'(1) + offset[cps_pkg::N_W-1:0];
				end else begin
					row_start_q <= row_end;
					pin_a_q     <= pin_a_q + cps_pkg::N_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign {high_a, bit_a} = pin_bit(pin_a_q, pins);
	assign {high_b, bit_b} = pin_bit(pin_b_q, pins);

	always_comb begin
		masks = '0;
		if (hit_q) begin
			if (high_a) masks.high_dir = masks.high_dir | bit_a;
			else        masks.low_dir  = masks.low_dir | bit_a;
			if (high_b) masks.high_dir = masks.high_dir | bit_b;
			else        masks.low_dir  = masks.low_dir | bit_b;
			if (!pol_q) begin
				if (high_a) masks.high_lvl = bit_a;
				else        masks.low_lvl  = bit_a;
			end else begin
				if (high_b) masks.high_lvl = bit_b;
				else        masks.low_lvl  = bit_b;
			end
		end
	end

	assign done = (state_q == D_OUT);

endmodule

@@ rtl/core/charlieplex_pwm_scanner.sv @@
// top level of the charlieplexed led pwm scanner
//
// usage: an item is taken when start is high and busy is low. action selects
// a tick, a duty write for one led (led_index, duty) or a clear of all duties.
// each item returns exactly one result: the four port images and current_led,
// valid in the single cycle where done is high. the receiver cannot stall, so
// done is a one-cycle strobe and the result is lost if not sampled then.
// sequence: set, clear and the unused action go from the exec state straight
// to done; a tick passes exec, an optional blank and advance and, when the
// scan moves to the next led, a read and an optional light before done. each
// blank and each light runs one decode that walks the pin rows up to the led's
// first pin, one row per cycle, then an output state. busy drops the cycle
// after done.
// the duty store is a 240-entry memory with one valid flag per entry; reset
// and a clear item drop all flags at once, so no sweep is needed.
// reset leaves the registers at low port pins 0..7 and no high-port pins, all
// duties zero, the scan on led 0 and all port images zero.
// configuration writes (cfg_write, cfg_index, cfg_data) are registered and
// are meant for idle periods only.
module charlieplex_pwm_scanner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      action,
	input  logic [7:0]                      led_index,
	input  logic [7:0]                      duty,
	input  logic                            cfg_write,
	input  logic [1:0]                      cfg_index,
	input  logic [3:0]                      cfg_data,
	output logic                            done,
	output logic [7:0]                      low_port_direction,
	output logic [7:0]                      low_port_level,
	output logic [7:0]                      high_port_direction,
	output logic [7:0]                      high_port_level,
	output logic [7:0]                      current_led
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_BLANK = 3'd2;
	localparam logic [2:0] S_ADV   = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_LIGHT = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	localparam int TW = cps_pkg::TICK_W;
	localparam int LW = cps_pkg::LED_W;
	localparam int CW = cps_pkg::CNT_W;
	localparam int NW = cps_pkg::N_W;

	// configuration registers
	logic [2:0] low_first_q;
	logic [3:0] low_count_q;
	logic [2:0] high_first_q;
	logic [3:0] high_count_q;

	// sequencer and scan state
	logic [2:0]              state_q;
	logic [1:0]              action_q;
	logic [LW-1:0]           index_q;
	logic [7:0]              duty_q;
	logic [CW-1:0]           scan_q;
	logic [TW-1:0]           tick_q;
	logic [TW-1:0]           slot_duty_q;
	cps_pkg::port_masks_t    img_q;

	// duty store: memory plus one valid flag per entry
	logic [TW-1:0]           duty_mem [cps_pkg::MAX_LEDS];
	logic [cps_pkg::MAX_LEDS-1:0] duty_vld_q;
	logic [TW-1:0]           rd_data_q;
	logic                    rd_vld_q;

	cps_pkg::pin_cfg_t       pins;
	cps_pkg::port_masks_t    dec_masks;
	logic                    dec_start;
	logic                    dec_done;

	logic [NW-1:0]           n_pins;
	logic [2*NW-1:0]         led_prod;
	logic [CW-1:0]           led_cnt;
	logic [TW-1:0]           tick_next;
	logic                    blank;
	logic [CW:0]             scan_plus;
	logic [CW-1:0]           scan_next;
	logic [TW-1:0]           duty_sat;
	logic [TW-1:0]           slot_next;
	logic                    mem_we;

	// pin counts above the port width use the whole port
	assign pins.n_low  = (low_count_q > 4'(cps_pkg::PORT_BITS))
		? cps_pkg::PCNT_W'(cps_pkg::PORT_BITS) : cps_pkg::PCNT_W'(low_count_q);
	assign pins.n_high = (high_count_q > 4'(cps_pkg::PORT_BITS))
		? cps_pkg::PCNT_W'(cps_pkg::PORT_BITS) : cps_pkg::PCNT_W'(high_count_q);
	assign pins.s_low  = cps_pkg::PSEL_W'(low_first_q);
	assign pins.s_high = cps_pkg::PSEL_W'(high_first_q);

	// led count n*(n-1), capped at the store depth
	assign n_pins   = NW'(pins.n_low) + NW'(pins.n_high);
	assign led_prod = (2*NW)'(n_pins) * (2*NW)'(n_pins - NW'(1));
	assign led_cnt  = (led_prod > (2*NW)'(cps_pkg::MAX_LEDS))
		? CW'(cps_pkg::MAX_LEDS) : led_prod[CW-1:0];

	assign tick_next = tick_q + TW'(1);
	assign blank     = (slot_duty_q == tick_next) && (scan_q < led_cnt);

	// next led of the scan, wrapping at the count or past it
	assign scan_plus = (CW+1)'(scan_q) + (CW+1)'(1);
	assign scan_next = (led_cnt == '0 || scan_plus >= (CW+1)'(led_cnt))
		? '0 : scan_plus[CW-1:0];

	assign duty_sat = (duty_q > 8'(cps_pkg::TICKS_PER_LED))
		? TW'(cps_pkg::TICKS_PER_LED) : duty_q[TW-1:0];
	assign slot_next = (led_cnt != '0 && rd_vld_q) ? rd_data_q : '0;

	assign mem_we = (state_q == S_EXEC) && (action_q == cps_pkg::ACT_SET)
		&& (CW'(index_q) < led_cnt);

	// the decoder always serves the led the scan points at
	assign dec_start = ((state_q == S_EXEC) && (action_q == cps_pkg::ACT_TICK) && blank)
		|| ((state_q == S_READ) && (slot_next != '0));

	cps_led_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dec_start),
		.led    (scan_q[LW-1:0]),
		.pins   (pins),
		.done   (dec_done),
		.masks  (dec_masks)
	);

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_first_q  <= 3'd0;
			low_count_q  <= 4'd8;
			high_first_q <= 3'd0;
			high_count_q <= 4'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				cps_pkg::CFG_LOW_FIRST:  low_first_q  <= cfg_data[2:0];
				cps_pkg::CFG_LOW_COUNT:  low_count_q  <= cfg_data;
				cps_pkg::CFG_HIGH_FIRST: high_first_q <= cfg_data[2:0];
				cps_pkg::CFG_HIGH_COUNT: high_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// duty memory, registered read of the next slot's entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			duty_mem[index_q] <= duty_sat;
		end
		if (state_q == S_ADV) begin
			rd_data_q <= duty_mem[scan_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (mem_we) begin
				duty_vld_q[index_q] <= 1'b1;
			end else if (state_q == S_EXEC && action_q == cps_pkg::ACT_CLEAR) begin
				duty_vld_q <= '0;
			end
			if (state_q == S_ADV) begin
				rd_vld_q <= duty_vld_q[scan_next];
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			action_q <= action;
			index_q  <= LW'(led_index);
			duty_q   <= duty;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			tick_q      <= '0;
			slot_duty_q <= '0;
			img_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (action_q == cps_pkg::ACT_TICK) begin
						tick_q  <= tick_next;
						state_q <= blank ? S_BLANK : S_ADV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_BLANK: begin
					if (dec_done) begin
						img_q   <= img_q & ~dec_masks;
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (tick_q >= TW'(cps_pkg::TICKS_PER_LED)) begin
						tick_q  <= '0;
						scan_q  <= scan_next;
						state_q <= S_READ;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					slot_duty_q <= slot_next;
					state_q     <= (slot_next != '0) ? S_LIGHT : S_DONE;
				end
				S_LIGHT: begin
					if (dec_done) begin
						img_q   <= img_q | dec_masks;
						state_q <= S_DONE;
					end
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy                = (state_q != S_IDLE);
	assign done                = (state_q == S_DONE);
	assign low_port_direction  = img_q.low_dir;
	assign low_port_level      = img_q.low_lvl;
	assign high_port_direction = img_q.high_dir;
	assign high_port_level     = img_q.high_lvl;
	assign current_led         = 8'(scan_q);

	// result strobe lasts a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item accepted but block not busy");

	// between items the tick counter stays inside the slot
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (tick_q < TW'(cps_pkg::TICKS_PER_LED)))
		else $error("tick counter left the slot range");

	// decoder only answers while the sequencer waits for it
	a_dec_owner: assert property (@(posedge clk) disable iff (!arst_n)
		dec_done |-> (state_q == S_BLANK || state_q == S_LIGHT))
		else $error("decoder finished outside a wait state");

	// latched slot duty never exceeds the slot length
	a_slot_duty: assert property (@(posedge clk) disable iff (!arst_n)
		slot_duty_q <= TW'(cps_pkg::TICKS_PER_LED))
		else $error("slot duty above ticks per led");

endmodule
